### rtl/tpg_pkg.sv
// Shared widths, reset values, codes and bundle types of the two-pad gesture block.
// Used by the channel interfaces and by every module of the block.
`default_nettype none

package tpg_pkg;

  localparam int unsigned ReadingW = 22;
  localparam int unsigned TimeW    = 32;
  localparam int unsigned MsW      = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 22;
  localparam int unsigned GestureW = 3;

  localparam logic [ReadingW-1:0] BaselineRst  = '0;
  localparam logic [ReadingW-1:0] ThresholdRst = ReadingW'(2000);
  localparam logic [MsW-1:0]      HoldMsRst    = MsW'(800);
  localparam logic [MsW-1:0]      BothHoldRst  = MsW'(3000);
  localparam logic [MsW-1:0]      TapGapRst    = MsW'(200);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_BASELINE_A = 3'd0,
    CFG_BASELINE_B = 3'd1,
    CFG_THRESHOLD  = 3'd2,
    CFG_HOLD_MS    = 3'd3,
    CFG_BOTH_HOLD  = 3'd4,
    CFG_TAP_GAP    = 3'd5
  } cfg_idx_e;

  typedef enum logic [GestureW-1:0] {
    GEST_NONE   = 3'd0,
    GEST_TAP_A  = 3'd1,
    GEST_TAP_B  = 3'd2,
    GEST_HOLD_A = 3'd3,
    GEST_HOLD_B = 3'd4,
    GEST_BOTH   = 3'd5
  } gesture_e;

  typedef struct packed {
    logic [ReadingW-1:0] baseline_a;
    logic [ReadingW-1:0] baseline_b;
    logic [ReadingW-1:0] threshold;
    logic [MsW-1:0]      hold_ms;
    logic [MsW-1:0]      both_hold_ms;
    logic [MsW-1:0]      tap_gap_ms;
  } cfg_t;

  // One scan after touch detection
  typedef struct packed {
    logic             touch_a;
    logic             touch_b;
    logic [TimeW-1:0] now_ms;
  } scan_t;

endpackage

`default_nettype wire

### rtl/tpg_if.sv
// Valid/ready channel interfaces: scan requests in, gesture results out, register writes.
// Depends on tpg_pkg for field widths.
`default_nettype none

interface tpg_scan_if
  import tpg_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [ReadingW-1:0] reading_a;
  logic [ReadingW-1:0] reading_b;
  logic [TimeW-1:0]    now_ms;

  modport source (output valid, reading_a, reading_b, now_ms, input ready);
  modport sink   (input valid, reading_a, reading_b, now_ms, output ready);
endinterface

interface tpg_gesture_if
  import tpg_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [GestureW-1:0] gesture;
  logic                pad_a_touched;
  logic                pad_b_touched;

  modport source (output valid, gesture, pad_a_touched, pad_b_touched, input ready);
  modport sink   (input valid, gesture, pad_a_touched, pad_b_touched, output ready);
endinterface

interface tpg_cfg_if
  import tpg_pkg::*;
();
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/tpg_cfg_regs.sv
// Configuration register file of the gesture block, written through the cfg channel.
// Depends on tpg_pkg and tpg_cfg_if.
`default_nettype none

module tpg_cfg_regs
  import tpg_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  tpg_cfg_if.sink    cfg,
  output cfg_t       cfg_o
);

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign cfg.ready = 1'b1;
  assign wr_en     = cfg.valid;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (cfg_idx_e'(cfg.index))
        CFG_BASELINE_A: cfg_d.baseline_a   = cfg.data[ReadingW-1:0];
        CFG_BASELINE_B: cfg_d.baseline_b   = cfg.data[ReadingW-1:0];
        CFG_THRESHOLD:  cfg_d.threshold    = cfg.data[ReadingW-1:0];
        CFG_HOLD_MS:    cfg_d.hold_ms      = cfg.data[MsW-1:0];
        CFG_BOTH_HOLD:  cfg_d.both_hold_ms = cfg.data[MsW-1:0];
        CFG_TAP_GAP:    cfg_d.tap_gap_ms   = cfg.data[MsW-1:0];
        default: ;  // drop writes past the register list
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.baseline_a   <= BaselineRst;
      cfg_q.baseline_b   <= BaselineRst;
      cfg_q.threshold    <= ThresholdRst;
      cfg_q.hold_ms      <= HoldMsRst;
      cfg_q.both_hold_ms <= BothHoldRst;
      cfg_q.tap_gap_ms   <= TapGapRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### rtl/tpg_scan_front.sv
// Input stage: compares each pad reading against baseline plus threshold and registers
// the touched flags with the timestamp. Depends on tpg_pkg and tpg_scan_if.
`default_nettype none

module tpg_scan_front
  import tpg_pkg::*;
(
  input  wire        clk_i,
  input  wire        rst_ni,
  input  cfg_t       cfg_i,
  tpg_scan_if.sink   scan,
  output logic       valid_o,
  input  wire        ready_i,
  output scan_t      scan_o
);

  logic signed [ReadingW+1:0] diff_a, diff_b, thr_s;
  logic  valid_q, valid_d;
  scan_t scan_q;
  logic  take;

  // signed rise above baseline, strictly above threshold
  assign diff_a = $signed({2'b00, scan.reading_a}) - $signed({2'b00, cfg_i.baseline_a});
  assign diff_b = $signed({2'b00, scan.reading_b}) - $signed({2'b00, cfg_i.baseline_b});
  assign thr_s  = $signed({2'b00, cfg_i.threshold});

  assign scan.ready = !valid_q || ready_i;
  assign take       = scan.valid && scan.ready;
  assign valid_d    = take || (valid_q && !ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      scan_q.touch_a <= diff_a > thr_s;
      scan_q.touch_b <= diff_b > thr_s;
      scan_q.now_ms  <= scan.now_ms;
    end
  end

  assign valid_o = valid_q;
  assign scan_o  = scan_q;

endmodule

`default_nettype wire

### rtl/tpg_gesture_core.sv
// Gesture decision: press tracking state, tap/hold/joint-hold checks and the result register.
// Depends on tpg_pkg and tpg_gesture_if.
`default_nettype none

module tpg_gesture_core
  import tpg_pkg::*;
(
  input  wire          clk_i,
  input  wire          rst_ni,
  input  cfg_t         cfg_i,
  input  wire          valid_i,
  output logic         ready_o,
  input  scan_t        scan_i,
  tpg_gesture_if.source res
);

  logic a, b, take;
  logic [TimeW-1:0] now;

  logic prev_a_q, prev_b_q;
  logic [TimeW-1:0] press_start_a_q, press_start_a_d, press_start_b_q, press_start_b_d;
  logic hold_done_a_q, hold_done_a_d, hold_done_b_q, hold_done_b_d;
  logic overlap_a_q, overlap_a_d, overlap_b_q, overlap_b_d;
  logic [TimeW-1:0] both_start_q, both_start_d;
  logic both_active_q, both_active_d, both_done_q, both_done_d;
  logic [TimeW-1:0] last_tap_a_q, last_tap_a_d, last_tap_b_q, last_tap_b_d;

  logic rise_a, rise_b, hd_a, hd_b;
  logic [TimeW-1:0] held_a, held_b, since_tap_a, since_tap_b, both_held;
  logic [TimeW-1:0] hold_lim, both_lim, gap_lim;
  logic fire_hold_a, fire_hold_b, fire_tap_a, fire_tap_b, fire_both;
  gesture_e gesture_d;

  logic     out_valid_q;
  gesture_e gesture_q;
  logic     touch_a_q, touch_b_q;

  assign a   = scan_i.touch_a;
  assign b   = scan_i.touch_b;
  assign now = scan_i.now_ms;

  assign ready_o = !out_valid_q || res.ready;
  assign take    = valid_i && ready_o;

  assign hold_lim = {{(TimeW-MsW){1'b0}}, cfg_i.hold_ms};
  assign both_lim = {{(TimeW-MsW){1'b0}}, cfg_i.both_hold_ms};
  assign gap_lim  = {{(TimeW-MsW){1'b0}}, cfg_i.tap_gap_ms};

  assign rise_a = a && !prev_a_q;
  assign rise_b = b && !prev_b_q;

  // Rising edge restarts the press
  assign press_start_a_d = rise_a ? now : press_start_a_q;
  assign press_start_b_d = rise_b ? now : press_start_b_q;
  assign hd_a            = rise_a ? 1'b0 : hold_done_a_q;
  assign hd_b            = rise_b ? 1'b0 : hold_done_b_q;
  assign overlap_a_d     = (a && b) || (rise_a ? b : overlap_a_q);
  assign overlap_b_d     = (a && b) || (rise_b ? a : overlap_b_q);

  assign held_a      = now - press_start_a_d;
  assign held_b      = now - press_start_b_d;
  assign since_tap_a = now - last_tap_a_q;
  assign since_tap_b = now - last_tap_b_q;

  assign fire_hold_a = a && !b && !overlap_a_d && !hd_a && (held_a > hold_lim);
  assign fire_hold_b = b && !a && !overlap_b_d && !hd_b && (held_b > hold_lim);
  assign fire_tap_a  = !a && prev_a_q && !overlap_a_d && !hd_a &&
                       (held_a < hold_lim) && (since_tap_a > gap_lim);
  assign fire_tap_b  = !b && prev_b_q && !overlap_b_d && !hd_b &&
                       (held_b < hold_lim) && (since_tap_b > gap_lim);

  assign hold_done_a_d = hd_a || fire_hold_a;
  assign hold_done_b_d = hd_b || fire_hold_b;
  assign last_tap_a_d  = fire_tap_a ? now : last_tap_a_q;
  assign last_tap_b_d  = fire_tap_b ? now : last_tap_b_q;

  // Joint hold timer runs only while both pads stay touched
  assign both_active_d = a && b;
  assign both_start_d  = (a && b && !both_active_q) ? now : both_start_q;
  assign both_held     = now - both_start_d;
  assign fire_both     = a && b && !(both_active_q && both_done_q) && (both_held > both_lim);
  assign both_done_d   = (a && b) ? ((both_active_q && both_done_q) || fire_both)
                                  : both_done_q;

  always_comb begin
    if (fire_hold_a) begin
      gesture_d = GEST_HOLD_A;
    end else if (fire_hold_b) begin
      gesture_d = GEST_HOLD_B;
    end else if (fire_tap_a) begin
      gesture_d = GEST_TAP_A;
    end else if (fire_tap_b) begin
      gesture_d = GEST_TAP_B;
    end else if (fire_both) begin
      gesture_d = GEST_BOTH;
    end else begin
      gesture_d = GEST_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_a_q        <= 1'b0;
      prev_b_q        <= 1'b0;
      press_start_a_q <= '0;
      press_start_b_q <= '0;
      hold_done_a_q   <= 1'b0;
      hold_done_b_q   <= 1'b0;
      overlap_a_q     <= 1'b0;
      overlap_b_q     <= 1'b0;
      both_start_q    <= '0;
      both_active_q   <= 1'b0;
      both_done_q     <= 1'b0;
      last_tap_a_q    <= '0;
      last_tap_b_q    <= '0;
      out_valid_q     <= 1'b0;
    end else begin
      if (take) begin
        prev_a_q        <= a;
        prev_b_q        <= b;
        press_start_a_q <= press_start_a_d;
        press_start_b_q <= press_start_b_d;
        hold_done_a_q   <= hold_done_a_d;
        hold_done_b_q   <= hold_done_b_d;
        overlap_a_q     <= overlap_a_d;
        overlap_b_q     <= overlap_b_d;
        both_start_q    <= both_start_d;
        both_active_q   <= both_active_d;
        both_done_q     <= both_done_d;
        last_tap_a_q    <= last_tap_a_d;
        last_tap_b_q    <= last_tap_b_d;
      end
      out_valid_q <= take || (out_valid_q && !res.ready);
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      gesture_q <= gesture_d;
      touch_a_q <= a;
      touch_b_q <= b;
    end
  end

  assign res.valid         = out_valid_q;
  assign res.gesture       = gesture_q;
  assign res.pad_a_touched = touch_a_q;
  assign res.pad_b_touched = touch_b_q;

endmodule

`default_nettype wire

### rtl/two_pad_touch_gesture_recognizer.sv
// Two-pad touch gesture recognizer: one gesture result per scan request.
// Each scan passes through the touch-compare input register, then through the gesture
// checks into the result register. Throughput is one scan per cycle as long as results
// are taken; a stalled result holds and the input register still takes one more request.
// Registers are written through the cfg channel (index 0..5: baseline A, baseline B,
// threshold, hold time, joint hold time, tap gap); other indexes are ignored. The user
// must write them only while no scan is in flight; the block does not enforce this.
// Depends on tpg_pkg, tpg_if, tpg_cfg_regs, tpg_scan_front and tpg_gesture_core.
`default_nettype none

module two_pad_touch_gesture_recognizer
  import tpg_pkg::*;
(
  input  wire            clk_i,
  input  wire            rst_ni,
  tpg_cfg_if.sink        cfg_i,
  tpg_scan_if.sink       scan_i,
  tpg_gesture_if.source  gesture_o
);

  cfg_t  cfg;
  logic  front_valid, core_ready;
  scan_t front_scan;

  tpg_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg    (cfg_i),
    .cfg_o  (cfg)
  );

  tpg_scan_front u_scan_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .scan    (scan_i),
    .valid_o (front_valid),
    .ready_i (core_ready),
    .scan_o  (front_scan)
  );

  tpg_gesture_core u_gesture_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (front_valid),
    .ready_o (core_ready),
    .scan_i  (front_scan),
    .res     (gesture_o)
  );

endmodule

`default_nettype wire
